### hw/rtl/mcts_pkg.sv
package mcts_pkg;

  // Field widths of the command and result words.
  localparam int DIM_IN_W  = 16;
  localparam int DIM_W     = 17;
  localparam int LAYER_W   = 16;
  localparam int LEVEL_W   = 5;
  localparam int BPP_W     = 8;
  localparam int TOTAL_W   = 53;

  // A level term is below 2^37 and the whole chain below 2^39.
  localparam int ACC_W     = 40;

  // Shared multiplier operand and product widths.
  localparam int MUL_A_W   = ACC_W;
  localparam int MUL_B_W   = DIM_W;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;

  localparam int DEFAULT_MAX_LEVELS = 31;

  typedef logic [DIM_IN_W-1:0] dim_t;

endpackage

### hw/rtl/mcts_mul.sv
module mcts_mul #(
  parameter int A_W = mcts_pkg::MUL_A_W,
  parameter int B_W = mcts_pkg::MUL_B_W
) (
  input  logic               clk,
  input  logic               en,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic [A_W+B_W-1:0] prod
);

  logic [A_W+B_W-1:0] a_ext;
  logic [A_W+B_W-1:0] b_ext;

  assign a_ext = {{B_W{1'b0}}, a};
  assign b_ext = {{A_W{1'b0}}, b};

  // Registered product; it holds its value while the unit is not enabled.
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a_ext * b_ext;
    end
  end

endmodule

### hw/rtl/mip_chain_texture_size_top.sv
// Channel  | Handshake     | Ports
// ---------+---------------+------------------------------------------------------
// command  | start & !busy | tex_width, tex_height, layer_count, level_count,
//          |               | pixel_bits, block_compressed
// result   | done strobe   | total_bytes
//
// done rises once the sequencer has worked through L levels, where L is the level count
// after clamping to 1..MAX_LEVELS: two passes of the shared multiplier per level (width by
// height, then by bits per pixel), then it adds the last term, multiplies once by the
// layer count and saturates. busy drops with done, so a new word is taken only after the
// last result. Synchronous reset returns the sequencer to idle and drops done.
// Results cannot be stalled and show for one cycle only.
module mip_chain_texture_size_top #(
  parameter int MAX_LEVELS = mcts_pkg::DEFAULT_MAX_LEVELS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [mcts_pkg::DIM_IN_W-1:0]   tex_width,
  input  logic [mcts_pkg::DIM_IN_W-1:0]   tex_height,
  input  logic [mcts_pkg::LAYER_W-1:0]    layer_count,
  input  logic [mcts_pkg::LEVEL_W-1:0]    level_count,
  input  logic [mcts_pkg::BPP_W-1:0]      pixel_bits,
  input  logic                            block_compressed,
  output logic                            done,
  output logic [mcts_pkg::TOTAL_W-1:0]    total_bytes
);

  import mcts_pkg::*;

  localparam int CNT_W = $clog2(MAX_LEVELS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIM   = 3'd1;
  localparam logic [2:0] S_BPP   = 3'd2;
  localparam logic [2:0] S_SUM   = 3'd3;
  localparam logic [2:0] S_LAYER = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]           state;
  dim_t                 w;
  dim_t                 h;
  logic [LAYER_W-1:0]   layers;
  logic [BPP_W-1:0]     bpp;
  logic                 bc;
  logic [CNT_W-1:0]     cnt;
  logic [ACC_W-1:0]     acc;
  logic                 have_term;

  logic                 mul_en;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [PROD_W-1:0]    prod;

  logic [DIM_W-1:0]     pw;
  logic [DIM_W-1:0]     ph;
  logic [DIM_W-1:0]     w_round;
  logic [DIM_W-1:0]     h_round;
  logic [ACC_W-1:0]     term;
  dim_t                 w_half;
  dim_t                 h_half;

  // Round up to a multiple of four for block-compressed formats.
  assign w_round = {1'b0, w} + DIM_W'(3);
  assign h_round = {1'b0, h} + DIM_W'(3);
  assign pw      = bc ? {w_round[DIM_W-1:2], 2'b00} : {1'b0, w};
  assign ph      = bc ? {h_round[DIM_W-1:2], 2'b00} : {1'b0, h};

  assign w_half  = (w[DIM_IN_W-1:1] == '0) ? DIM_IN_W'(1) : {1'b0, w[DIM_IN_W-1:1]};
  assign h_half  = (h[DIM_IN_W-1:1] == '0) ? DIM_IN_W'(1) : {1'b0, h[DIM_IN_W-1:1]};

  // The product register still holds the last level's bit count here.
  assign term    = prod[ACC_W+2:3];

  assign busy    = (state != S_IDLE);

  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state)
      S_DIM: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(pw);
        mul_b  = ph;
      end
      S_BPP: begin
        mul_en = 1'b1;
        mul_a  = prod[MUL_A_W-1:0];
        mul_b  = MUL_B_W'(bpp);
      end
      S_LAYER: begin
        mul_en = 1'b1;
        mul_a  = acc;
        mul_b  = MUL_B_W'(layers);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  mcts_mul #(
    .A_W (MUL_A_W),
    .B_W (MUL_B_W)
  ) u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == S_OUT);
      case (state)
        S_IDLE: begin
          if (start) begin
            w         <= (tex_width == '0) ? DIM_IN_W'(1) : tex_width;
            h         <= (tex_height == '0) ? DIM_IN_W'(1) : tex_height;
            layers    <= (layer_count == '0) ? LAYER_W'(1) : layer_count;
            bpp       <= pixel_bits;
            bc        <= block_compressed;
            acc       <= '0;
            have_term <= 1'b0;
            if (level_count == '0) begin
              cnt <= CNT_W'(1);
            end else if (int'(level_count) > MAX_LEVELS) begin
              cnt <= CNT_W'(MAX_LEVELS);
            end else begin
              cnt <= CNT_W'(level_count);
            end
            state <= S_DIM;
          end
        end
        S_DIM: begin
          if (have_term) begin
            acc <= acc + term;
          end
          state <= S_BPP;
        end
        S_BPP: begin
          w         <= w_half;
          h         <= h_half;
          have_term <= 1'b1;
          cnt       <= cnt - CNT_W'(1);
          state     <= (cnt == CNT_W'(1)) ? S_SUM : S_DIM;
        end
        S_SUM: begin
          acc   <= acc + term;
          state <= S_LAYER;
        end
        S_LAYER: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (prod[PROD_W-1:TOTAL_W] != '0) begin
            total_bytes <= '1;
          end else begin
            total_bytes <= prod[TOTAL_W-1:0];
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### bench/mip_chain_size_checker.sv
`timescale 1ns / 100ps

module mip_chain_size_checker #(
  parameter int MAX_LEVELS = mcts_pkg::DEFAULT_MAX_LEVELS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            busy,
  input  logic [mcts_pkg::DIM_IN_W-1:0]   tex_width,
  input  logic [mcts_pkg::DIM_IN_W-1:0]   tex_height,
  input  logic [mcts_pkg::LAYER_W-1:0]    layer_count,
  input  logic [mcts_pkg::LEVEL_W-1:0]    level_count,
  input  logic [mcts_pkg::BPP_W-1:0]      pixel_bits,
  input  logic                            block_compressed,
  input  logic                            done,
  input  logic [mcts_pkg::TOTAL_W-1:0]    total_bytes,
  output int                              fail_count,
  output int                              pending
);
  import mcts_pkg::*;

  localparam logic [63:0] TOTAL_LIMIT = (64'd1 << TOTAL_W) - 64'd1;

  logic [TOTAL_W-1:0] expected_totals[$];
  int errors = 0;

  assign fail_count = errors;
  assign pending    = expected_totals.size();

  // Sum of every level of the chain, times the layer count, clipped to the
  // width of the result. 64 bits hold the unclipped product with room to spare.
  function automatic logic [TOTAL_W-1:0] chain_bytes(
    input dim_t                 w_in,
    input dim_t                 h_in,
    input logic [LAYER_W-1:0]   layers_in,
    input logic [LEVEL_W-1:0]   levels_in,
    input logic [BPP_W-1:0]     bpp,
    input logic                 padded
  );
    logic [63:0] w, h, pw, ph, sum;
    int          n, i;
    w   = (w_in == '0) ? 64'd1 : 64'(w_in);
    h   = (h_in == '0) ? 64'd1 : 64'(h_in);
    n   = (levels_in == '0) ? 1 : int'(levels_in);
    if (n > MAX_LEVELS) n = MAX_LEVELS;
    sum = '0;
    for (i = 0; i < n; i++) begin
      pw  = padded ? ((w + 64'd3) >> 2) << 2 : w;
      ph  = padded ? ((h + 64'd3) >> 2) << 2 : h;
      sum = sum + ((pw * ph * 64'(bpp)) >> 3);
      w   = ((w >> 1) == '0) ? 64'd1 : (w >> 1);
      h   = ((h >> 1) == '0) ? 64'd1 : (h >> 1);
    end
    sum = sum * ((layers_in == '0) ? 64'd1 : 64'(layers_in));
    if (sum > TOTAL_LIMIT) sum = TOTAL_LIMIT;
    return sum[TOTAL_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (expected_totals.size() == 0) begin
          $display("%0t: result word with nothing expected, total_bytes %0d",
                   $time, total_bytes);
          errors++;
        end else begin
          if (total_bytes !== expected_totals[0]) begin
            $display("%0t: total_bytes expected %0d, actual %0d",
                     $time, expected_totals[0], total_bytes);
            errors++;
          end
          void'(expected_totals.pop_front());
        end
      end
      if (start && !busy)
        expected_totals = {expected_totals,
                           chain_bytes(tex_width, tex_height, layer_count,
                                       level_count, pixel_bits,
                                       block_compressed)};
    end
  end

endmodule

### bench/mip_chain_texture_size_top_test.sv
`timescale 1ns / 100ps

module mip_chain_texture_size_top_test;
  import mcts_pkg::*;

  localparam int RANDOM_WORDS = 500;
  localparam int CALM_WORDS   = 100;
  localparam int DRAIN_CYCLES = 2 * DEFAULT_MAX_LEVELS + 20;

  logic                clk = 1'b0;
  logic                rst;
  logic                start;
  logic                busy;
  logic [DIM_IN_W-1:0] tex_width;
  logic [DIM_IN_W-1:0] tex_height;
  logic [LAYER_W-1:0]  layer_count;
  logic [LEVEL_W-1:0]  level_count;
  logic [BPP_W-1:0]    pixel_bits;
  logic                block_compressed;
  logic                done;
  logic [TOTAL_W-1:0]  total_bytes;
  int                  fail_count;
  int                  pending;

  mip_chain_texture_size_top dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .tex_width        (tex_width),
    .tex_height       (tex_height),
    .layer_count      (layer_count),
    .level_count      (level_count),
    .pixel_bits       (pixel_bits),
    .block_compressed (block_compressed),
    .done             (done),
    .total_bytes      (total_bytes)
  );

  mip_chain_size_checker checker_i (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .tex_width        (tex_width),
    .tex_height       (tex_height),
    .layer_count      (layer_count),
    .level_count      (level_count),
    .pixel_bits       (pixel_bits),
    .block_compressed (block_compressed),
    .done             (done),
    .total_bytes      (total_bytes),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  always #10 clk = ~clk;

  // Holds start until the word is taken. A nonzero gap drops start for that
  // many cycles, either right away or once the block has gone idle again.
  task automatic send_texture(
    input dim_t               w,
    input dim_t               h,
    input logic [LAYER_W-1:0] layers,
    input logic [LEVEL_W-1:0] levels,
    input logic [BPP_W-1:0]   bpp,
    input logic               padded,
    input int                 gap
  );
    tex_width        <= w;
    tex_height       <= h;
    layer_count      <= layers;
    level_count      <= levels;
    pixel_bits       <= bpp;
    block_compressed <= padded;
    start            <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      if ($urandom_range(0, 1) == 1) begin
        @(posedge clk);
        while (busy) @(posedge clk);
      end
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic dim_t pick_dim();
    case ($urandom_range(0, 3))
      0: return dim_t'($urandom_range(0, 65535));
      1: return dim_t'($urandom_range(0, 70));
      2: return dim_t'(1 << $urandom_range(0, 15));
      default: return dim_t'($urandom_range(65000, 65535));
    endcase
  endfunction

  function automatic logic [BPP_W-1:0] pick_bpp();
    logic [BPP_W-1:0] usual[12] = '{0, 1, 2, 4, 8, 16, 24, 32, 48, 64, 96, 128};
    if ($urandom_range(0, 1) == 1) return usual[$urandom_range(0, 11)];
    return BPP_W'($urandom_range(0, 255));
  endfunction

  initial begin
    int k, gap;
    logic [LAYER_W-1:0] layers;
    rst              <= 1'b1;
    start            <= 1'b0;
    tex_width        <= '0;
    tex_height       <= '0;
    layer_count      <= '0;
    level_count      <= '0;
    pixel_bits       <= '0;
    block_compressed <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero fields act as one; zero bit depth gives nothing at any size.
    send_texture(16'd0, 16'd0, 16'd0, 5'd0, 8'd8, 1'b0, 0);
    send_texture(16'd1, 16'd1, 16'd1, 5'd1, 8'd1, 1'b0, 0);
    send_texture(16'd1, 16'd1, 16'd1, 5'd1, 8'd4, 1'b1, 2);
    send_texture(16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd31, 8'd0, 1'b1, 0);
    send_texture(16'd0, 16'd0, 16'd0, 5'd0, 8'd0, 1'b0, 0);
    // Full base size, both padding modes, deepest chain.
    send_texture(16'hFFFF, 16'hFFFF, 16'd1, 5'd31, 8'd128, 1'b0, 0);
    send_texture(16'hFFFF, 16'hFFFF, 16'd1, 5'd31, 8'd128, 1'b1, 1);
    // Largest layer count at legal depth stays below the clip.
    send_texture(16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd31, 8'd128, 1'b1, 0);
    // Bit depths above the normal range; the two all-ones sizes clip the result.
    send_texture(16'd640, 16'd480, 16'd6, 5'd10, 8'd129, 1'b0, 0);
    send_texture(16'd1023, 16'd17, 16'd3, 5'd12, 8'd255, 1'b1, 0);
    send_texture(16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd31, 8'd255, 1'b1, 3);
    send_texture(16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd31, 8'd255, 1'b0, 0);
    send_texture(16'h8000, 16'hFFFF, 16'hFFFF, 5'd2, 8'd200, 1'b0, 0);
    // Odd and narrow shapes: padding and the floor at one pixel.
    send_texture(16'd5, 16'd3, 16'd2, 5'd4, 8'd4, 1'b1, 0);
    send_texture(16'hFFFF, 16'd1, 16'd1, 5'd31, 8'd32, 1'b1, 0);
    send_texture(16'd1, 16'hFFFF, 16'd7, 5'd31, 8'd24, 1'b0, 4);
    send_texture(16'd0, 16'hFFFF, 16'd1, 5'd20, 8'd8, 1'b1, 0);
    send_texture(16'd7, 16'd9, 16'd0, 5'd3, 8'd3, 1'b0, 0);
    send_texture(16'd1024, 16'd1024, 16'd6, 5'd11, 8'd32, 1'b0, 0);
    send_texture(16'd1024, 16'd1024, 16'd6, 5'd11, 8'd8, 1'b1, 0);

    for (k = 0; k < RANDOM_WORDS; k++) begin
      gap = 0;
      if (k < RANDOM_WORDS - CALM_WORDS && $urandom_range(0, 2) == 0)
        gap = $urandom_range(1, 4);
      layers = ($urandom_range(0, 1) == 1) ? LAYER_W'($urandom_range(0, 65535))
                                           : LAYER_W'($urandom_range(0, 8));
      send_texture(pick_dim(), pick_dim(), layers, LEVEL_W'($urandom_range(0, 31)),
                   pick_bpp(), 1'($urandom_range(0, 1)), gap);
    end
    start <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("mip_chain_texture_size_top verification clean");
    else
      $display("mip_chain_texture_size_top verification failed");
    $finish;
  end

  initial begin
    #5000000;
    $display("mip_chain_texture_size_top verification failed");
    $finish;
  end

endmodule
